[design/dcfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfr_pkg
// Shared types, codes and helper functions of the command frame receiver.
// ----------------------------------------------------------------------------
package dcfr_pkg;

    localparam int BUFFER_DEPTH_DEFAULT = 512;

    localparam int BYTE_W      = 8;
    localparam int POS_OUT_W   = 9;
    localparam int KIND_W      = 3;
    localparam int SIDE_W      = 2;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 8;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_DROP_WHILE_PENDING    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPTURE_SIDE_COMMANDS = CFG_INDEX_W'(1);

    localparam logic [BYTE_W-1:0] CHAR_DOLLAR  = 8'h24;
    localparam logic [BYTE_W-1:0] CHAR_HASH    = 8'h23;
    localparam logic [BYTE_W-1:0] CHAR_LBRACE  = 8'h7B;
    localparam logic [BYTE_W-1:0] CHAR_RBRACE  = 8'h7D;
    localparam logic [BYTE_W-1:0] CHAR_LT      = 8'h3C;
    localparam logic [BYTE_W-1:0] CHAR_GT      = 8'h3E;
    localparam logic [BYTE_W-1:0] CHAR_BANG    = 8'h21;
    localparam logic [BYTE_W-1:0] SIDE_CMD_ONE = 8'h01;
    localparam logic [BYTE_W-1:0] SIDE_CMD_TWO = 8'h02;

    localparam logic [KIND_W-1:0] KIND_IDLE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DOLLAR = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HASH   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BRACE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ANGLE  = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DOLLAR = 5'b00010,
        ST_HASH   = 5'b00100,
        ST_BRACE  = 5'b01000,
        ST_ANGLE  = 5'b10000
    } frame_state_t;

    typedef struct packed {
        frame_state_t            state;
        logic                    pending;
        logic [SIDE_W-1:0]       side;
    } ctrl_t;

    typedef struct packed {
        logic drop_while_pending;
        logic capture_side_commands;
    } cfg_t;

    typedef struct packed {
        logic                    byte_stored;
        logic [BYTE_W-1:0]       stored_byte;
        logic [POS_OUT_W-1:0]    stored_position;
        logic [KIND_W-1:0]       frame_kind;
        logic                    frame_end;
        logic                    frame_pending;
        logic [SIDE_W-1:0]       side_command;
    } result_t;

    function automatic frame_state_t start_state(input logic [BYTE_W-1:0] b);
        frame_state_t s;
        priority if (b == CHAR_DOLLAR) s = ST_DOLLAR;
        else if (b == CHAR_HASH)       s = ST_HASH;
        else if (b == CHAR_LBRACE)     s = ST_BRACE;
        else if (b == CHAR_LT)         s = ST_ANGLE;
        else                           s = ST_IDLE;
        return s;
    endfunction

    function automatic logic ends_frame(input frame_state_t s, input logic [BYTE_W-1:0] b);
        logic e;
        unique case (s)
            ST_DOLLAR: e = (b == CHAR_BANG);
            ST_HASH:   e = (b == CHAR_BANG);
            ST_BRACE:  e = (b == CHAR_RBRACE);
            ST_ANGLE:  e = (b == CHAR_GT);
            ST_IDLE:   e = 1'b0;
            default:   e = 1'b0;
        endcase
        return e;
    endfunction

    function automatic logic [KIND_W-1:0] kind_code(input frame_state_t s);
        logic [KIND_W-1:0] k;
        unique case (s)
            ST_DOLLAR: k = KIND_DOLLAR;
            ST_HASH:   k = KIND_HASH;
            ST_BRACE:  k = KIND_BRACE;
            ST_ANGLE:  k = KIND_ANGLE;
            ST_IDLE:   k = KIND_IDLE;
            default:   k = KIND_IDLE;
        endcase
        return k;
    endfunction

endpackage

[design/dcfr_rx_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfr_rx_if
// Input channel: received byte or release request.
// ----------------------------------------------------------------------------
interface dcfr_rx_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [dcfr_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

[design/dcfr_result_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfr_result_if
// Result channel: one item per accepted input item.
// ----------------------------------------------------------------------------
interface dcfr_result_if;
    logic                           valid;
    logic                           ready;
    logic                           byte_stored;
    logic [dcfr_pkg::BYTE_W-1:0]    stored_byte;
    logic [dcfr_pkg::POS_OUT_W-1:0] stored_position;
    logic [dcfr_pkg::KIND_W-1:0]    frame_kind;
    logic                           frame_end;
    logic                           frame_pending;
    logic [dcfr_pkg::SIDE_W-1:0]    side_command;

    modport source (
        output valid, output byte_stored, output stored_byte, output stored_position,
        output frame_kind, output frame_end, output frame_pending, output side_command,
        input ready
    );
    modport sink (
        input valid, input byte_stored, input stored_byte, input stored_position,
        input frame_kind, input frame_end, input frame_pending, input side_command,
        output ready
    );
endinterface

[design/dcfr_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface dcfr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [dcfr_pkg::CFG_INDEX_W-1:0] index;
    logic [dcfr_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/dcfr_frame_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfr_frame_decoder
// Next-state and result logic for one received byte or release item.
// ----------------------------------------------------------------------------
module dcfr_frame_decoder #(
    parameter int BUFFER_DEPTH = dcfr_pkg::BUFFER_DEPTH_DEFAULT,
    parameter int POS_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
    input  dcfr_pkg::cfg_t                 cfg,
    input  dcfr_pkg::ctrl_t                cur,
    input  logic [POS_W-1:0]               cur_pos,
    input  logic                           operation,
    input  logic [dcfr_pkg::BYTE_W-1:0]    rx_byte,
    output dcfr_pkg::ctrl_t                nxt,
    output logic [POS_W-1:0]               nxt_pos,
    output dcfr_pkg::result_t              res
);
    import dcfr_pkg::*;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BUFFER_DEPTH - 1);

    frame_state_t      kind_sel;
    logic [POS_W-1:0]  pos_sel;
    logic [31:0]       cur_pos_wide;
    logic [31:0]       pos_sel_wide;

    assign cur_pos_wide = 32'(cur_pos);
    assign pos_sel_wide = 32'(pos_sel);

    always_comb
    begin
        nxt      = cur;
        nxt_pos  = cur_pos;
        kind_sel = cur.state;
        pos_sel  = cur_pos;
        res      = '0;
        res.stored_position = cur_pos_wide[POS_OUT_W-1:0];

        if (operation == OP_RELEASE)
        begin
            nxt.pending = 1'b0;
            nxt.state   = ST_IDLE;
        end
        else
        begin
            if (cfg.capture_side_commands && (rx_byte == SIDE_CMD_ONE || rx_byte == SIDE_CMD_TWO))
            begin
                nxt.side = rx_byte[SIDE_W-1:0];
            end

            if (!(cfg.drop_while_pending && cur.pending))
            begin
                priority if (rx_byte == CHAR_LT)
                begin
                    kind_sel = ST_ANGLE;
                    pos_sel  = '0;
                end
                else if (cur.state == ST_IDLE)
                begin
                    kind_sel = start_state(rx_byte);
                    pos_sel  = '0;
                end
                else
                begin
                    // inside a frame: keep kind and position
                    kind_sel = cur.state;
                    pos_sel  = cur_pos;
                end

                res.byte_stored     = 1'b1;
                res.stored_byte     = rx_byte;
                res.stored_position = pos_sel_wide[POS_OUT_W-1:0];

                if (ends_frame(kind_sel, rx_byte))
                begin
                    nxt.pending   = 1'b1;
                    res.frame_end = 1'b1;
                end

                nxt_pos   = (pos_sel == POS_LAST) ? '0 : pos_sel + POS_W'(1);
                nxt.state = kind_sel;
            end
        end

        res.frame_kind    = kind_code(nxt.state);
        res.frame_pending = nxt.pending;
        res.side_command  = nxt.side;
    end

endmodule

[design/delimited_command_frame_receiver_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_command_frame_receiver_core
// Frames '$', '#', '{' and '<' delimited text commands from received bytes.
// ----------------------------------------------------------------------------
// the result is registered and appears in the cycle after the item is accepted
// throughput: one item per cycle while the result channel does not stall, set by the single registered state update
// the result register frees itself in the cycle its item is taken
// reset: asynchronous active-low; idle, no pending frame, position 0,
//   side command none, drop_while_pending 1, capture_side_commands 0
module delimited_command_frame_receiver_core #(
    parameter int BUFFER_DEPTH = dcfr_pkg::BUFFER_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    dcfr_rx_if.sink     rx,
    dcfr_result_if.source result,
    dcfr_cfg_if.sink    cfg
);
    import dcfr_pkg::*;

    localparam int POS_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    cfg_t              cfg_reg;
    ctrl_t             ctrl_reg;
    ctrl_t             ctrl_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    result_t           res_next;
    result_t           res_reg;
    logic              out_valid_reg;
    logic              rx_accept;
    logic              cfg_accept;

    assign rx.ready   = !out_valid_reg || result.ready;
    assign rx_accept  = rx.valid && rx.ready;
    assign cfg.ready  = 1'b1;
    assign cfg_accept = cfg.valid && cfg.ready;

    dcfr_frame_decoder #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .POS_W        (POS_W)
    ) u_decoder (
        .cfg       (cfg_reg),
        .cur       (ctrl_reg),
        .cur_pos   (pos_reg),
        .operation (rx.operation),
        .rx_byte   (rx.rx_byte),
        .nxt       (ctrl_next),
        .nxt_pos   (pos_next),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drop_while_pending    <= 1'b1;
            cfg_reg.capture_side_commands <= 1'b0;
        end
        else if (cfg_accept)
        begin
            if (cfg.index == CFG_DROP_WHILE_PENDING)
            begin
                cfg_reg.drop_while_pending <= cfg.data[0];
            end
            else if (cfg.index == CFG_CAPTURE_SIDE_COMMANDS)
            begin
                cfg_reg.capture_side_commands <= cfg.data[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.state   <= ST_IDLE;
            ctrl_reg.pending <= 1'b0;
            ctrl_reg.side    <= '0;
            pos_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (rx_accept)
            begin
                ctrl_reg      <= ctrl_next;
                pos_reg       <= pos_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_accept)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.byte_stored     = res_reg.byte_stored;
    assign result.stored_byte     = res_reg.stored_byte;
    assign result.stored_position = res_reg.stored_position;
    assign result.frame_kind      = res_reg.frame_kind;
    assign result.frame_end       = res_reg.frame_end;
    assign result.frame_pending   = res_reg.frame_pending;
    assign result.side_command    = res_reg.side_command;

    // a completed frame always shows as pending in the same item
    a_end_implies_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.frame_end) |-> result.frame_pending)
        else $error("frame_end without frame_pending");

    // nothing stored means no byte and no frame end
    a_unstored_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.byte_stored) |-> (result.stored_byte == '0 && !result.frame_end))
        else $error("unstored item carries byte or frame end");

    // release item clears the flag and returns to idle
    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_accept && rx.operation == OP_RELEASE)
        |=> (!ctrl_reg.pending && ctrl_reg.state == ST_IDLE && result.frame_kind == KIND_IDLE))
        else $error("release did not clear frame state");

    // every accepted item is offered as a result in the next cycle
    a_accept_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        rx_accept |=> result.valid)
        else $error("accepted item produced no result");

endmodule
